>>> rtl/core/hcfv_pkg.sv
package hcfv_pkg;

    localparam int RADIUS_W     = 15;
    localparam int LENGTH_W     = 15;
    localparam int DEPTH_W      = 16;
    localparam int VOLUME_W     = 47;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;

    localparam int CORDIC_STEPS = 24;

    localparam int D_W          = 16;
    localparam int RSQ_W        = 2 * RADIUS_W;
    localparam int ROOT_W       = 31;
    localparam int REM_W        = 63;
    localparam int SQ_STAGES    = ROOT_W;
    localparam int CW           = 36;
    localparam int ZW           = 34;
    localparam int P1_W         = RSQ_W + ZW - 1;
    localparam int P2_W         = D_W + ROOT_W + 1;
    localparam int A16_W        = 50;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [VOLUME_W-1:0]  VOL_MAX     = {VOLUME_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_LENGTH = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [D_W-1:0] d;
        logic                  clamped;
        logic [ROOT_W-1:0]     s;
    } sq_out_t;

    typedef struct packed {
        logic signed [D_W-1:0] d;
        logic                  clamped;
        logic [ROOT_W-1:0]     s;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } cor_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            default: v = (i <= 30) ? (ZW'(1) << (30 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/hcfv_if.sv
interface hcfv_depth_if;
    import hcfv_pkg::*;
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_mm;
    modport source (output valid, output depth_mm, input ready);
    modport sink   (input valid, input depth_mm, output ready);
endinterface

interface hcfv_volume_if;
    import hcfv_pkg::*;
    logic                valid;
    logic                ready;
    logic [VOLUME_W-1:0] volume_mm3;
    logic                depth_clamped;
    modport source (output valid, output volume_mm3, output depth_clamped, input ready);
    modport sink   (input valid, input volume_mm3, input depth_clamped, output ready);
endinterface

interface hcfv_cfg_if;
    import hcfv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/hcfv_sqrt.sv
module hcfv_sqrt
    import hcfv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [RADIUS_W-1:0] radius,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DEPTH_W-1:0]  in_depth,
    output logic                out_valid,
    input  logic                out_ready,
    output sq_out_t             out_data
);

    localparam int NS = SQ_STAGES + 2;

    typedef struct packed {
        logic signed [D_W-1:0] d;
        logic                  clamped;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
    } sq_t;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] vin;
    logic [NS:0]   rdy;

    logic [DEPTH_W-1:0]    two_r;
    logic [DEPTH_W-1:0]    h_c;
    logic                  clamp_c;
    logic [D_W:0]          d_wide;
    logic signed [D_W-1:0] d0_reg;
    logic                  cl0_reg;
    logic [DEPTH_W-1:0]    h0_reg;
    logic [DEPTH_W-1:0]    hr0_reg;
    logic [2*DEPTH_W-1:0]  rad;

    sq_t sq_reg [1:NS-1];

    assign rdy[NS] = out_ready;
    assign vin     = {valid_reg[NS-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    endgenerate

    assign valid_next = (rdy[NS-1:0] & vin) | (~rdy[NS-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        two_r   = {radius, 1'b0};
        clamp_c = in_depth > two_r;
        h_c     = clamp_c ? two_r : in_depth;
        d_wide  = {2'b00, radius} - {1'b0, h_c};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && vin[0])
        begin
            d0_reg  <= $signed(d_wide[D_W-1:0]);
            cl0_reg <= clamp_c;
            h0_reg  <= h_c;
            hr0_reg <= two_r - h_c;
        end
    end

    assign rad = {{DEPTH_W{1'b0}}, h0_reg} * {{DEPTH_W{1'b0}}, hr0_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[1] && vin[1])
        begin
            sq_reg[1].d       <= d0_reg;
            sq_reg[1].clamped <= cl0_reg;
            sq_reg[1].rem     <= {1'b0, rad[RSQ_W-1:0], 32'b0};
            sq_reg[1].root    <= '0;
        end
    end

    generate
        for (k = 0; k < SQ_STAGES; k++) begin : g_sq
            localparam int B = ROOT_W - 1 - k;
            logic [REM_W-1:0] trial;
            sq_t              nxt;

            always_comb
            begin
                nxt   = sq_reg[k+1];
                trial = (REM_W'(sq_reg[k+1].root) << (B + 1)) + (REM_W'(1) << (2 * B));
                if (sq_reg[k+1].rem >= trial)
                begin
                    nxt.rem     = sq_reg[k+1].rem - trial;
                    nxt.root[B] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k+2] && vin[k+2])
                begin
                    sq_reg[k+2] <= nxt;
                end
            end
        end
    endgenerate

    assign in_ready         = rdy[0];
    assign out_valid        = valid_reg[NS-1];
    assign out_data.d       = sq_reg[NS-1].d;
    assign out_data.clamped = sq_reg[NS-1].clamped;
    assign out_data.s       = sq_reg[NS-1].root;

endmodule

>>> rtl/core/hcfv_cordic.sv
module hcfv_cordic
    import hcfv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sq_out_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cor_t    out_data
);

    localparam int NS = CORDIC_STEPS + 1;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] vin;
    logic [NS:0]   rdy;

    logic signed [CW-1:0] x0;
    cor_t                 pre;
    cor_t                 cor_reg [0:NS-1];

    assign rdy[NS] = out_ready;
    assign vin     = {valid_reg[NS-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    endgenerate

    assign valid_next = (rdy[NS-1:0] & vin) | (~rdy[NS-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        x0          = {{(CW-D_W-16){in_data.d[D_W-1]}}, in_data.d, 16'b0};
        pre.d       = in_data.d;
        pre.clamped = in_data.clamped;
        pre.s       = in_data.s;
        if (in_data.d[D_W-1])
        begin
            pre.x = $signed(CW'(in_data.s));
            pre.y = -x0;
            pre.z = HALF_PI_Q30;
        end
        else
        begin
            pre.x = x0;
            pre.y = $signed(CW'(in_data.s));
            pre.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && vin[0])
        begin
            cor_reg[0] <= pre;
        end
    end

    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_iter
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            cor_t                 nxt;

            always_comb
            begin
                nxt = cor_reg[k];
                xs  = $signed(cor_reg[k].x) >>> k;
                ys  = $signed(cor_reg[k].y) >>> k;
                if (!cor_reg[k].y[CW-1])
                begin
                    nxt.x = $signed(cor_reg[k].x) + ys;
                    nxt.y = $signed(cor_reg[k].y) - xs;
                    nxt.z = $signed(cor_reg[k].z) + atan_entry(k);
                end
                else
                begin
                    nxt.x = $signed(cor_reg[k].x) - ys;
                    nxt.y = $signed(cor_reg[k].y) + xs;
                    nxt.z = $signed(cor_reg[k].z) - atan_entry(k);
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k+1] && vin[k+1])
                begin
                    cor_reg[k+1] <= nxt;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NS-1];
    assign out_data  = cor_reg[NS-1];

endmodule

>>> rtl/core/hcfv_area.sv
module hcfv_area
    import hcfv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [RSQ_W-1:0]    rsq,
    input  logic [LENGTH_W-1:0] length,
    input  logic                in_valid,
    output logic                in_ready,
    input  cor_t                in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VOLUME_W-1:0] volume,
    output logic                clamped
);

    localparam int NS     = 4;
    localparam int PROD_W = A16_W + LENGTH_W;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] vin;
    logic [NS:0]   rdy;

    logic [ZW-2:0]            zc;
    logic [P1_W-1:0]          p1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic                     cl_a_reg;
    logic                     cl_b_reg;
    logic                     cl_c_reg;
    logic                     cl_d_reg;
    logic signed [63:0]       area;
    logic [63:0]              area_rnd;
    logic [A16_W-1:0]         a16_reg;
    logic [PROD_W-1:0]        prod_full;
    logic [63:0]              prod_reg;
    logic [63:0]              vol_rnd;
    logic [VOLUME_W:0]        vol_q;
    logic [VOLUME_W-1:0]      vol_reg;

    assign rdy[NS] = out_ready;
    assign vin     = {valid_reg[NS-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_rdy
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    endgenerate

    assign valid_next = (rdy[NS-1:0] & vin) | (~rdy[NS-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign zc = in_data.z[ZW-1] ? '0 : in_data.z[ZW-2:0];

    always_ff @(posedge clk)
    begin
        if (rdy[0] && vin[0])
        begin
            p1_reg   <= P1_W'(rsq) * P1_W'(zc);
            p2_reg   <= P2_W'($signed(in_data.d)) * P2_W'($signed({1'b0, in_data.s}));
            cl_a_reg <= in_data.clamped;
        end
    end

    always_comb
    begin
        area     = $signed({1'b0, p1_reg}) - ($signed({{(64-P2_W){p2_reg[P2_W-1]}}, p2_reg}) <<< 14);
        area_rnd = (area[63] ? 64'd0 : area) + 64'd8192;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && vin[1])
        begin
            a16_reg  <= area_rnd[A16_W+13:14];
            cl_b_reg <= cl_a_reg;
        end
    end

    assign prod_full = PROD_W'(a16_reg) * PROD_W'(length);

    always_ff @(posedge clk)
    begin
        if (rdy[2] && vin[2])
        begin
            prod_reg <= prod_full[63:0];
            cl_c_reg <= cl_b_reg;
        end
    end

    always_comb
    begin
        vol_rnd = prod_reg + 64'd32768;
        vol_q   = vol_rnd[16+VOLUME_W:16];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3] && vin[3])
        begin
            vol_reg  <= (vol_rnd[63:16] > 48'(VOL_MAX)) ? VOL_MAX : vol_q[VOLUME_W-1:0];
            cl_d_reg <= cl_c_reg;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NS-1];
    assign volume    = vol_reg;
    assign clamped   = cl_d_reg;

endmodule

>>> rtl/core/horizontal_cylinder_fill_volume_top.sv
// Liquid volume of a horizontal cylinder from its fill depth. Write the radius (index 0) and
// length (index 1) in mm through cfg while no request is in flight; each depth request gives
// one volume in mm^3, rounded to nearest, with depth_clamped set when the depth exceeded the
// diameter. One request is taken every clock unless the output stalls; it passes the 33-stage
// clamp and bit-per-stage square root, the 25-stage CORDIC and the 4-stage area and volume
// multiplier path. A stalled output holds its result while earlier stages keep filling.
module horizontal_cylinder_fill_volume_top
    import hcfv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hcfv_cfg_if.sink      cfg,
    hcfv_depth_if.sink    depth,
    hcfv_volume_if.source volume
);

    logic [RADIUS_W-1:0] radius_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [RSQ_W-1:0]    rsq_reg;

    logic    sq_valid;
    logic    sq_ready;
    sq_out_t sq_data;
    logic    cor_valid;
    logic    cor_ready;
    cor_t    cor_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(1);
            length_reg <= LENGTH_W'(1);
            rsq_reg    <= RSQ_W'(1);
        end
        else
        begin
            rsq_reg <= RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_RADIUS: radius_reg <= cfg.data;
                    CFG_LENGTH: length_reg <= cfg.data;
                    default:    ;
                endcase
            end
        end
    end

    hcfv_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius    (radius_reg),
        .in_valid  (depth.valid),
        .in_ready  (depth.ready),
        .in_depth  (depth.depth_mm),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    hcfv_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_data  (cor_data)
    );

    hcfv_area u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .rsq       (rsq_reg),
        .length    (length_reg),
        .in_valid  (cor_valid),
        .in_ready  (cor_ready),
        .in_data   (cor_data),
        .out_valid (volume.valid),
        .out_ready (volume.ready),
        .volume    (volume.volume_mm3),
        .clamped   (volume.depth_clamped)
    );

endmodule

>>> tb/sv/horizontal_cylinder_fill_volume_top_test.sv
`timescale 1ns / 1ps

module horizontal_cylinder_fill_volume_top_test;
    import hcfv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_IDLE     = 18;

    typedef struct packed {
        logic [VOLUME_W-1:0] volume;
        logic                clamped;
    } fill_result_t;

    logic clk;
    logic rst_n;

    hcfv_cfg_if    cfg_if();
    hcfv_depth_if  depth_if();
    hcfv_volume_if volume_if();

    horizontal_cylinder_fill_volume_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if.sink),
        .depth  (depth_if.sink),
        .volume (volume_if.source)
    );

    logic [RADIUS_W-1:0] radius_reg;
    logic [LENGTH_W-1:0] length_reg;
    fill_result_t        pending_volumes[$];
    int                  mismatches;
    int                  cycle_count;
    bit                  idling_on;
    int                  holdoff_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int draw_idle();
        return idling_on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint arctan_step(input int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tbl[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic fill_result_t predict_volume(input logic [DEPTH_W-1:0] depth);
        fill_result_t res;
        longint r, h, d, x, y, z, t, xs, ys, area;
        longint unsigned s, a16, vol;
        r = longint'(radius_reg);
        h = longint'(depth);
        res.clamped = 1'b0;
        if (h > 2 * r)
        begin
            h = 2 * r;
            res.clamped = 1'b1;
        end
        d = r - h;
        s = int_sqrt(longint'(r * r - d * d) << 32);
        x = d * 65536;
        y = longint'(s);
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = 1686629713;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
        end
        if (z < 0)
            z = 0;
        area = r * r * z - d * longint'(s) * 16384;
        if (area < 0)
            area = 0;
        a16 = (longint'(area) + 8192) >> 14;
        vol = (a16 * longint'(length_reg) + 32768) >> 16;
        if (vol > (64'd1 << 47) - 1)
            vol = (64'd1 << 47) - 1;
        res.volume = vol[VOLUME_W-1:0];
        return res;
    endfunction

    task automatic send_depth(input logic [DEPTH_W-1:0] depth);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            depth_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        depth_if.valid    <= 1'b1;
        depth_if.depth_mm <= depth;
        @(posedge clk);
        while (!depth_if.ready)
            @(posedge clk);
        pending_volumes.push_back(predict_volume(depth));
    endtask

    task automatic wait_idle();
        depth_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_volumes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (index == CFG_RADIUS)
            radius_reg = data;
        else if (index == CFG_LENGTH)
            length_reg = data;
        @(posedge clk);
    endtask

    task automatic set_tank(input logic [RADIUS_W-1:0] r, input logic [LENGTH_W-1:0] l);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_LENGTH, l);
    endtask

    task automatic test_reset_tank();
        send_depth(16'd0);
        send_depth(16'd1);
        send_depth(16'd2);
        send_depth(16'd3);
        send_depth(16'hFFFF);
    endtask

    task automatic test_extremes();
        set_tank(15'h7FFF, 15'h7FFF);
        send_depth(16'd0);
        send_depth(16'd1);
        send_depth(16'd32766);
        send_depth(16'd32767);
        send_depth(16'd32768);
        send_depth(16'd65533);
        send_depth(16'd65534);
        send_depth(16'd65535);
        set_tank(15'd1, 15'h7FFF);
        send_depth(16'd1);
        send_depth(16'd2);
    endtask

    task automatic test_zero_dimensions();
        set_tank(15'd0, 15'd100);
        send_depth(16'd0);
        send_depth(16'd5);
        send_depth(16'hAAAA);
        set_tank(15'd500, 15'd0);
        send_depth(16'd250);
        send_depth(16'd1000);
        send_depth(16'h5555);
    endtask

    task automatic test_unused_index();
        set_tank(15'd300, 15'd700);
        write_reg(CFG_UNUSED_A, 15'h7FFF);
        write_reg(CFG_UNUSED_B, 15'd0);
        send_depth(16'd150);
        send_depth(16'd600);
    endtask

    task automatic test_random_tanks();
        logic [RADIUS_W-1:0] r;
        for (int phase = 0; phase < 10; phase++)
        begin
            idling_on = (phase % 3) != 2;
            case (phase % 4)
                0: r = RADIUS_W'($urandom_range(1, 40));
                1: r = RADIUS_W'($urandom_range(1, 2000));
                2: r = RADIUS_W'($urandom_range(16384, 32767));
                default: r = RADIUS_W'($urandom_range(0, 32767));
            endcase
            set_tank(r, LENGTH_W'($urandom_range(0, 32767)));
            repeat (100)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_depth(DEPTH_W'($urandom_range(0, 2 * int'(radius_reg))));
                else
                    send_depth(DEPTH_W'($urandom_range(0, 65535)));
            end
        end
        idling_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_tank(15'd12345, 15'd321);
        idling_on = 1'b0;
        holdoff_cycles = 300;
        repeat (120) send_depth(DEPTH_W'($urandom_range(0, 24690)));
        idling_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        int gap;
        if (!rst_n)
        begin
            volume_if.ready <= 1'b0;
            gap = 0;
        end
        else
        begin
            if (volume_if.valid && volume_if.ready)
                gap = draw_idle();
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles = holdoff_cycles - 1;
                volume_if.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap = gap - 1;
                volume_if.ready <= 1'b0;
            end
            else
                volume_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        fill_result_t want;
        if (rst_n && volume_if.valid && volume_if.ready)
        begin
            if (pending_volumes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected volume %0d clamped %0b",
                             volume_if.volume_mm3, volume_if.depth_clamped);
            end
            else
            begin
                want = pending_volumes.pop_front();
                if (volume_if.volume_mm3 !== want.volume
                    || volume_if.depth_clamped !== want.clamped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("volume mismatch: expected %0d/%0b got %0d/%0b",
                                 want.volume, want.clamped,
                                 volume_if.volume_mm3, volume_if.depth_clamped);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_RADIUS;
        cfg_if.data       = '0;
        depth_if.valid    = 1'b0;
        depth_if.depth_mm = '0;
        volume_if.ready   = 1'b0;
        radius_reg        = 15'd1;
        length_reg        = 15'd1;
        mismatches        = 0;
        cycle_count       = 0;
        idling_on         = 1'b1;
        holdoff_cycles    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_tank();
        test_extremes();
        test_zero_dimensions();
        test_unused_index();
        test_backpressure();
        test_random_tanks();
        wait_idle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
